// ----- rtl/xnks_pkg.sv -----
// Package for the XOR nearest-k search unit: sizes, constants and shared types.
// No dependencies.
`timescale 1ns / 1ps
package xnks_pkg;
  localparam int CAPACITY = 1024;
  localparam int MAX_K = 64;
  localparam int ID_W = 64;
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int K_W = $clog2(MAX_K + 1);
  localparam int KIDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] K_RESET = 7'd20;
  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic store_wr;
    logic list_clear;
    logic scan_start;
    logic scan_step;
  } xnks_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic emit_last;
    logic full;
    logic empty;
  } xnks_stat_t;
endpackage

// ----- rtl/xnks_datapath.sv -----
// Datapath: identifier memory, sorted nearest list with insertion shift, emit mux.
// Depends on xnks_pkg.
`timescale 1ns / 1ps
module xnks_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  xnks_pkg::xnks_cmd_t     cmd,
  output xnks_pkg::xnks_stat_t    stat,
  input  logic [63:0]             in_value,
  input  logic [xnks_pkg::K_W-1:0] k_eff,
  input  logic [xnks_pkg::KIDX_W-1:0] emit_idx,
  output logic [63:0]             emit_value,
  output logic [xnks_pkg::K_W-1:0] held_cnt
);
  import xnks_pkg::*;

  logic [ID_W-1:0] mem [CAPACITY];
  logic [ID_W-1:0] rd_data;
  logic            rd_valid;
  logic [CNT_W-1:0] stored_count;
  logic [CNT_W-1:0] scan_addr;
  logic [ID_W-1:0] key;
  logic [ID_W-1:0] list [MAX_K];
  logic [ID_W-1:0] list_next [MAX_K];
  logic [K_W-1:0]  held;
  logic [K_W-1:0]  held_next;
  logic [MAX_K-1:0] gt;

  assign stat.full = (stored_count == CNT_W'(CAPACITY));
  assign stat.empty = (stored_count == '0);
  assign stat.scan_done = !rd_valid && (scan_addr == stored_count);
  assign stat.emit_last = (K_W'(emit_idx) + K_W'(1) == held);
  assign held_cnt = held;
  assign emit_value = list[emit_idx];

  always_ff @(posedge clk) begin
    if (cmd.store_wr && !stat.full) begin
      mem[stored_count[ADDR_W-1:0]] <= in_value;
    end
    rd_data <= mem[scan_addr[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      rd_valid <= 1'b0;
      scan_addr <= '0;
    end else begin
      if (cmd.store_wr && !stat.full) begin
        stored_count <= stored_count + CNT_W'(1);
      end
      if (cmd.scan_start) begin
        scan_addr <= '0;
        rd_valid <= 1'b0;
        key <= in_value;
      end else if (cmd.scan_step) begin
        rd_valid <= (scan_addr != stored_count);
        if (scan_addr != stored_count) begin
          scan_addr <= scan_addr + CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    logic [ID_W-1:0] d;
    logic full_list;
    d = rd_data ^ key;
    full_list = (held == k_eff);
    for (int i = 0; i < MAX_K; i++) begin
      gt[i] = (K_W'(i) < held) && ((list[i] ^ key) > d);
    end
    held_next = held;
    for (int i = 0; i < MAX_K; i++) begin
      list_next[i] = list[i];
    end
    if (rd_valid && !(full_list && !gt[k_eff[KIDX_W-1:0] - KIDX_W'(1)])) begin
      if (!full_list) begin
        held_next = held + K_W'(1);
      end
      for (int i = 0; i < MAX_K; i++) begin
        if (K_W'(i) < held_next) begin
          if (gt[i]) begin
            list_next[i] = (i == 0) ? rd_data : (gt[(i == 0) ? 0 : i - 1] ? list[(i == 0) ? 0 : i - 1] : rd_data);
          end else if (K_W'(i) >= held) begin
            list_next[i] = (i == 0) ? rd_data : (gt[(i == 0) ? 0 : i - 1] ? list[(i == 0) ? 0 : i - 1] : rd_data);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (cmd.list_clear) begin
      held <= '0;
    end else if (cmd.scan_step) begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      for (int i = 0; i < MAX_K; i++) begin
        list[i] <= list_next[i];
      end
    end
  end
endmodule

// ----- rtl/xnks_ctrl.sv -----
// Controller: accepts beats, sequences scan and emission, owns config and overflow flag.
// Depends on xnks_pkg.
`timescale 1ns / 1ps
module xnks_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_fire,
  input  logic                    in_action,
  output logic                    in_rdy,
  output logic                    out_vld,
  input  logic                    out_rdy,
  output logic                    out_last,
  output logic                    out_none,
  output logic                    out_ovf,
  input  logic                    cfg_we,
  input  logic [xnks_pkg::CFG_W-1:0] cfg_data,
  output xnks_pkg::xnks_cmd_t     cmd,
  input  xnks_pkg::xnks_stat_t    stat,
  output logic [xnks_pkg::K_W-1:0] k_eff,
  output logic [xnks_pkg::KIDX_W-1:0] emit_idx
);
  import xnks_pkg::*;

  typedef enum logic [1:0] {IDLE, SCAN, EMIT, NONE} state_t;
  state_t state;
  logic [CFG_W-1:0] k_reg;
  logic ovf;

  always_comb begin
    if (k_reg == '0) k_eff = K_W'(1);
    else if (k_reg > CFG_W'(MAX_K)) k_eff = K_W'(MAX_K);
    else k_eff = K_W'(k_reg);
  end

  assign in_rdy = (state == IDLE);
  assign out_vld = (state == EMIT) || (state == NONE);
  assign out_none = (state == NONE);
  assign out_last = (state == NONE) || stat.emit_last;
  assign out_ovf = ovf;

  always_comb begin
    cmd = '0;
    cmd.store_wr = in_fire && (in_action == ACT_ADD);
    cmd.scan_start = in_fire && (in_action == ACT_QUERY);
    cmd.list_clear = cmd.scan_start;
    cmd.scan_step = (state == SCAN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      k_reg <= K_RESET;
      ovf <= 1'b0;
      emit_idx <= '0;
    end else begin
      if (cfg_we) k_reg <= cfg_data;
      case (state)
        IDLE: begin
          if (in_fire) begin
            if (in_action == ACT_ADD) begin
              if (stat.full) ovf <= 1'b1;
            end else if (stat.empty) begin
              state <= NONE;
            end else begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (stat.scan_done) begin
            state <= EMIT;
            emit_idx <= '0;
          end
        end
        EMIT: begin
          if (out_rdy) begin
            if (stat.emit_last) state <= IDLE;
            else emit_idx <= emit_idx + KIDX_W'(1);
          end
        end
        NONE: begin
          if (out_rdy) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/xor_nearest_k_search_unit.sv -----
// Top level of the XOR nearest-k search unit: stream ports, controller and datapath.
// Depends on xnks_pkg, xnks_ctrl, xnks_datapath.
`timescale 1ns / 1ps
// A query scans every stored entry once, one per cycle through the identifier
// memory read port, and then gives its result beats, each held until it is
// taken; the block takes no new beat until the last result of a query is
// taken.
module xor_nearest_k_search_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // value
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // found_value
  output logic        m_axis_tlast,   // last
  output logic [1:0]  m_axis_tuser,   // [1] store_overflowed, [0] none_found
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data
);
  import xnks_pkg::*;

  xnks_cmd_t cmd;
  xnks_stat_t stat;
  logic [K_W-1:0] k_eff;
  logic [K_W-1:0] held_cnt;
  logic [KIDX_W-1:0] emit_idx;
  logic [63:0] emit_value;
  logic none, ovf;
  logic in_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  xnks_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_action(s_axis_tuser),
    .in_rdy(s_axis_tready), .out_vld(m_axis_tvalid), .out_rdy(m_axis_tready),
    .out_last(m_axis_tlast), .out_none(none), .out_ovf(ovf),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .cmd(cmd), .stat(stat),
    .k_eff(k_eff), .emit_idx(emit_idx)
  );

  xnks_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .in_value(s_axis_tdata),
    .k_eff(k_eff), .emit_idx(emit_idx), .emit_value(emit_value),
    .held_cnt(held_cnt)
  );

  assign m_axis_tdata = (none || held_cnt == '0) ? 64'd0 : emit_value;
  assign m_axis_tuser = {ovf, none};
endmodule
